### rtl/core/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
`timescale 1ns / 1ps

package tccw_pkg;

    localparam logic       OP_PUT      = 1'b0;
    localparam logic       OP_READ     = 1'b1;

    localparam logic [7:0] CH_BS       = 8'd8;
    localparam logic [7:0] CH_NL       = 8'd10;
    localparam logic [7:0] CH_ESC      = 8'd27;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] RESET_COLOR = 8'h07;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLANK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [10:0] cursor_offset;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
    } result_t;

endpackage

### rtl/core/tccw_ram.sv
// Screen store: single-port RAM, one write or read a cycle, registered read data.
`timescale 1ns / 1ps

module tccw_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [15:0]       wdata,
    output logic [15:0]       rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/tccw_agu.sv
// Shared address unit: row times column count plus offset.
`timescale 1ns / 1ps

module tccw_agu #(
    parameter int COLUMNS = 80,
    parameter int MUL_W   = 5,
    parameter int ADD_W   = 11,
    parameter int ADDR_W  = 11
) (
    input  logic [MUL_W-1:0]  mul,
    input  logic [ADD_W-1:0]  add,
    output logic [ADDR_W-1:0] sum
);

    localparam int         PW    = MUL_W + 8;
    localparam logic [7:0] COLS8 = 8'(COLUMNS);

    logic [PW-1:0] prod;
    logic [PW:0]   full;

    assign prod = PW'(mul) * PW'(COLS8);
    assign full = (PW + 1)'(prod) + (PW + 1)'(add);
    assign sum  = full[ADDR_W-1:0];

endmodule

### rtl/core/tccw_ctrl.sv
// Sequencer: cursor, attribute register, store clear, put/read handling and scroll.
`timescale 1ns / 1ps

module tccw_ctrl
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_char_code,
    input  logic [4:0]  s_read_row,
    input  logic [6:0]  s_read_col,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        out_free,
    output logic        res_load,
    output result_t     res
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int MUL_W  = (ROW_W > 5) ? ROW_W : 5;
    localparam int ADD_W  = (ADDR_W > 7) ? ADDR_W : 7;
    localparam int OFF_W  = (ADDR_W > 11) ? ADDR_W : 11;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        color_reg;
    logic              op_reg;
    logic [7:0]        ch_reg;
    logic [4:0]        rr_reg;
    logic [6:0]        rc_reg;
    logic [15:0]       cell_reg, cell_next;

    logic [MUL_W-1:0]  agu_mul;
    logic [ADD_W-1:0]  agu_add;
    logic [ADDR_W-1:0] agu_sum;
    logic [OFF_W-1:0]  off_ext;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_rdata;

    logic              rd_in_range;
    logic              at_last_col;
    logic              at_last_row;

    tccw_agu #(
        .COLUMNS (COLUMNS),
        .MUL_W   (MUL_W),
        .ADD_W   (ADD_W),
        .ADDR_W  (ADDR_W)
    ) u_agu (
        .mul (agu_mul),
        .add (agu_add),
        .sum (agu_sum)
    );

    tccw_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_in_range = ({2'b00, rr_reg} < 7'(ROWS)) && ({1'b0, rc_reg} < 8'(COLUMNS));
    assign at_last_col = (col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row = (row_reg == ROW_W'(ROWS - 1));
    assign off_ext     = OFF_W'(agu_sum);
    assign s_ready     = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            color_reg <= RESET_COLOR;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end
        end
    end

    // word capture and read result hold
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_op;
            ch_reg <= s_char_code;
            rr_reg <= s_read_row;
            rc_reg <= s_read_col;
        end
        cell_reg <= cell_next;
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cell_next  = cell_reg;
        agu_mul    = MUL_W'(row_reg);
        agu_add    = ADD_W'(col_reg);
        ram_we     = 1'b0;
        ram_addr   = agu_sum;
        ram_wdata  = {color_reg, CH_SPACE};
        res_load   = 1'b0;
        res.cursor_offset = off_ext[10:0];
        res.cell_char     = cell_reg[7:0];
        res.cell_color    = cell_reg[15:8];

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = idx_reg;
                ram_wdata = {RESET_COLOR, CH_SPACE};
                idx_next  = idx_reg + ADDR_W'(1);
                if (idx_reg == ADDR_W'(CELLS - 1)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cell_next  = '0;
                state_next = ST_DONE;
                if (op_reg == OP_READ) begin
                    agu_mul = MUL_W'(rr_reg);
                    agu_add = ADD_W'(rc_reg);
                    if (rd_in_range) begin
                        state_next = ST_RD_WAIT;
                    end
                end else begin
                    case (ch_reg)
                        CH_BS: begin
                            agu_add = ADD_W'(col_reg - COL_W'(1));
                            if (col_reg != '0) begin
                                ram_we   = 1'b1;
                                col_next = col_reg - COL_W'(1);
                            end
                        end
                        CH_NL: begin
                            col_next = '0;
                            if (at_last_row) begin
                                idx_next   = '0;
                                state_next = ST_SCR_RD;
                            end else begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                        CH_ESC: begin
                        end
                        default: begin
                            ram_wdata = {color_reg, ch_reg};
                            if (at_last_col) begin
                                ram_we = (ch_reg != CH_SPACE);
                            end else begin
                                ram_we   = 1'b1;
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                cell_next  = ram_rdata;
                state_next = ST_DONE;
            end
            ST_SCR_RD: begin
                // fetch the cell one row below
                agu_mul    = MUL_W'(1);
                agu_add    = ADD_W'(idx_reg);
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                ram_we    = 1'b1;
                ram_addr  = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + ADDR_W'(1);
                if (idx_reg == ADDR_W'(CELLS - COLUMNS - 1)) begin
                    state_next = ST_BLANK;
                end else begin
                    state_next = ST_SCR_RD;
                end
            end
            ST_BLANK: begin
                ram_we   = 1'b1;
                ram_addr = idx_reg;
                idx_next = idx_reg + ADDR_W'(1);
                if (idx_reg == ADDR_W'(CELLS - 1)) begin
                    idx_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/text_console_cell_writer.sv
// A newline on the bottom row scrolls, which walks the store through its single port.
// One word at a time: the next word is accepted once the result sits in the output register.
// Reset (synchronous, aresetn low): cursor to 0, attribute to 7, then a clearing pass over all
// ROWS*COLUMNS cells writes blanks to the store; no word is accepted until it ends.
`timescale 1ns / 1ps

module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_char_code,
    input  logic [4:0]  s_read_row,
    input  logic [6:0]  s_read_col,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_cursor_offset,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_color,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    logic    m_valid_reg;
    result_t out_reg;
    result_t res;
    logic    res_load;
    logic    out_free;

    assign out_free = !m_valid_reg || m_ready;

    tccw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_char_code (s_char_code),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_offset = out_reg.cursor_offset;
    assign m_cell_char     = out_reg.cell_char;
    assign m_cell_color    = out_reg.cell_color;

endmodule

### rtl/core/tccw_checker.sv
// Port-level checks for the text console cell writer, bound to the top level.
`timescale 1ns / 1ps

module tccw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_op,
    input logic [7:0]  s_char_code,
    input logic [4:0]  s_read_row,
    input logic [6:0]  s_read_col,
    input logic        m_valid,
    input logic        m_ready,
    input logic [10:0] m_cursor_offset,
    input logic [7:0]  m_cell_char,
    input logic [7:0]  m_cell_color
);

    // one word in flight: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high the cycle after an accept");

    // a result never appears the cycle right after its word is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_offset)
            && $stable(m_cell_char) && $stable(m_cell_color))
        else $error("stalled result changed");

    // a new read word taken while a result is stalled leaves that result in place
    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op && m_valid && !m_ready |=> m_valid)
        else $error("stalled result dropped");

    // offered word held until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_op) && $stable(s_char_code)
            && $stable(s_read_row) && $stable(s_read_col))
        else $error("offered word changed before accept");

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_op            (s_op),
    .s_char_code     (s_char_code),
    .s_read_row      (s_read_row),
    .s_read_col      (s_read_col),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_cursor_offset (m_cursor_offset),
    .m_cell_char     (m_cell_char),
    .m_cell_color    (m_cell_color)
);

### verif/text_console_cell_writer_checker.sv
// Checker for the text console cell writer: predicts every result word and compares it.
`timescale 1ns / 1ps

module text_console_cell_writer_checker
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_char_code,
    input  logic [4:0]  s_read_row,
    input  logic [6:0]  s_read_col,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [10:0] m_cursor_offset,
    input  logic [7:0]  m_cell_char,
    input  logic [7:0]  m_cell_color,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    output int unsigned pending_results,
    output int unsigned mismatch_count
);

    localparam int CELLS = ROWS * COLUMNS;

    logic [15:0] screen_cells [CELLS];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [7:0]  attr_byte;
    result_t     expected_results [$];
    int unsigned fails;
    int unsigned results_checked;

    function void put_char(input logic [7:0] ch);
        int unsigned at;
        int i;
        at = cur_row * COLUMNS + cur_col;
        if (ch == CH_BS) begin
            if (cur_col > 0) begin
                cur_col--;
                screen_cells[at - 1] = {attr_byte, CH_SPACE};
            end
        end else if (ch == CH_NL) begin
            cur_col = 0;
            if (cur_row < ROWS - 1) begin
                cur_row++;
            end else begin
                // scroll: every row moves up one, bottom row blanked
                for (i = 0; i < CELLS - COLUMNS; i++)
                    screen_cells[i] = screen_cells[i + COLUMNS];
                for (i = CELLS - COLUMNS; i < CELLS; i++)
                    screen_cells[i] = {attr_byte, CH_SPACE};
            end
        end else if (ch != CH_ESC) begin
            if (cur_col >= COLUMNS - 1) begin
                // last column: overwrite in place, spaces dropped
                if (ch != CH_SPACE)
                    screen_cells[at] = {attr_byte, ch};
            end else begin
                screen_cells[at] = {attr_byte, ch};
                cur_col++;
            end
        end
    endfunction

    function result_t predict_word(input logic op, input logic [7:0] ch,
                                   input logic [4:0] row, input logic [6:0] col);
        result_t     r;
        logic [15:0] cell_word;
        r = '0;
        if (op == OP_PUT) begin
            put_char(ch);
        end else if (row < ROWS && col < COLUMNS) begin
            cell_word    = screen_cells[row * COLUMNS + col];
            r.cell_char  = cell_word[7:0];
            r.cell_color = cell_word[15:8];
        end
        r.cursor_offset = 11'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++)
                screen_cells[i] = {RESET_COLOR, CH_SPACE};
            cur_row   = 0;
            cur_col   = 0;
            attr_byte = RESET_COLOR;
            expected_results.delete();
        end else begin
            if (cfg_wr_en)
                attr_byte = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: unexpected result word offset %0d char %h colour %h",
                                 $realtime, m_cursor_offset, m_cell_char, m_cell_color);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_cursor_offset !== want.cursor_offset ||
                        m_cell_char !== want.cell_char ||
                        m_cell_color !== want.cell_color) begin
                        if (fails < 10)
                            $display({"%0t: result %0d mismatch: expected offset %0d ",
                                      "char %h colour %h, got offset %0d char %h colour %h"},
                                     $realtime, results_checked, want.cursor_offset,
                                     want.cell_char, want.cell_color, m_cursor_offset,
                                     m_cell_char, m_cell_color);
                        fails++;
                    end
                end
                results_checked++;
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_word(s_op, s_char_code,
                                                        s_read_row, s_read_col));
        end
        pending_results <= expected_results.size();
        mismatch_count  <= fails;
    end

endmodule

### verif/text_console_cell_writer_test.sv
// Testbench top for the text console cell writer: stimulus, output flow control and verdict.
`timescale 1ns / 1ps

module text_console_cell_writer_test;
    import tccw_pkg::*;

    localparam int          COLUMNS        = 80;
    localparam int          ROWS           = 25;
    localparam int          PHASE_WORDS    = 155;
    localparam int          QUIET_TAIL     = 100;
    localparam int          LONG_HOLD      = 300;
    localparam int          HOLD_AT_RESULT = 300;
    localparam int unsigned STUCK_LIMIT    = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [7:0]  s_char_code;
    logic [4:0]  s_read_row;
    logic [6:0]  s_read_col;
    logic        m_valid;
    logic        m_ready;
    logic [10:0] m_cursor_offset;
    logic [7:0]  m_cell_char;
    logic [7:0]  m_cell_color;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    int unsigned pending_results;
    int unsigned mismatch_count;
    int unsigned stuck_cycles;
    int unsigned words_sent;
    int unsigned puts_sent;
    int unsigned reads_sent;
    int unsigned colours_set;
    bit          no_idle;
    bit          sender_calm;

    text_console_cell_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_char_code    (s_char_code),
        .s_read_row     (s_read_row),
        .s_read_col     (s_read_col),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_offset(m_cursor_offset),
        .m_cell_char    (m_cell_char),
        .m_cell_color   (m_cell_color),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    text_console_cell_writer_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_char_code    (s_char_code),
        .s_read_row     (s_read_row),
        .s_read_col     (s_read_col),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_offset(m_cursor_offset),
        .m_cell_char    (m_cell_char),
        .m_cell_color   (m_cell_color),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .pending_results(pending_results),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge aclk);
        $display("Watchdog: no word moved for %0d cycles", STUCK_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Output side: random hold-off bursts, calm stretches, one long hold-off.
    initial begin
        int unsigned gap_left;
        int unsigned results_seen;
        int unsigned stretch_left;
        bit          hold_done;
        bit          calm;
        gap_left     = 0;
        results_seen = 0;
        stretch_left = 0;
        hold_done    = 1'b0;
        calm         = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                results_seen++;
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(40, 160);
                calm = ($urandom_range(0, 2) == 0);
            end
            stretch_left--;
            if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                gap_left  = LONG_HOLD;
            end
            if (gap_left > 0) begin
                m_ready <= 1'b0;
                gap_left--;
            end else if (!no_idle && !calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                gap_left = $urandom_range(1, 7) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic op, input logic [7:0] ch,
                             input logic [4:0] row, input logic [6:0] col);
        s_valid     <= 1'b1;
        s_op        <= op;
        s_char_code <= ch;
        s_read_row  <= row;
        s_read_col  <= col;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (op == OP_PUT)
            puts_sent++;
        else
            reads_sent++;
        if (!no_idle && !sender_calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // Puts carry junk in the read coordinates, reads carry junk in the character.
    task automatic put_word(input logic [7:0] ch);
        send_word(OP_PUT, ch, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_word(input logic [4:0] row, input logic [6:0] col);
        send_word(OP_READ, 8'($urandom), row, col);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    task automatic set_colour(input logic [7:0] value);
        wait_all_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        colours_set++;
    endtask

    function automatic logic [7:0] control_char();
        case ($urandom_range(0, 4))
            0: return CH_BS;
            1: return CH_NL;
            2: return CH_ESC;
            3: return CH_SPACE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int unsigned phase_end);
        int unsigned n;
        while (words_sent < phase_end) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if (words_sent + QUIET_TAIL >= phase_end && phase_end >= 6 * PHASE_WORDS)
                no_idle <= 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // a line of text, long ones run into the last column
                    n = ($urandom_range(0, 2) == 0) ? $urandom_range(70, 100)
                                                    : $urandom_range(3, 20);
                    repeat (n) put_word(8'($urandom_range(32, 126)));
                    if ($urandom_range(0, 3) != 0)
                        put_word(CH_NL);
                end
                4, 5: begin
                    repeat ($urandom_range(3, 10)) put_word(control_char());
                end
                6, 7: begin
                    repeat ($urandom_range(2, 6)) begin
                        if ($urandom_range(0, 4) == 0)
                            read_word(5'($urandom), 7'($urandom));
                        else
                            read_word(5'($urandom_range(0, ROWS - 1)),
                                      7'($urandom_range(0, COLUMNS - 1)));
                    end
                end
                8: begin
                    repeat ($urandom_range(3, 8))
                        send_word(1'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
                end
                default: begin
                    repeat ($urandom_range(2, 10)) put_word(CH_BS);
                    repeat ($urandom_range(0, 4)) put_word(8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        logic [7:0]  colours [6];
        int unsigned first_words;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_op        <= OP_PUT;
        s_char_code <= 8'h00;
        s_read_row  <= 5'd0;
        s_read_col  <= 7'd0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'h00;
        no_idle     <= 1'b0;
        sender_calm = 1'b0;
        words_sent  = 0;
        puts_sent   = 0;
        reads_sent  = 0;
        colours_set = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // cells straight after the clearing pass, corners and off-screen reads
        read_word(5'd0, 7'd0);
        read_word(5'(ROWS - 1), 7'(COLUMNS - 1));
        read_word(5'h1F, 7'h7F);
        read_word(5'(ROWS), 7'd0);
        read_word(5'd0, 7'(COLUMNS));
        put_word(8'h41);
        put_word(8'h00);
        put_word(8'hFF);
        put_word(CH_BS);
        put_word(CH_BS);
        put_word(CH_BS);
        put_word(CH_BS);                // backspace at column zero
        put_word(CH_ESC);
        put_word(CH_SPACE);
        put_word(CH_NL);
        read_word(5'd0, 7'd0);
        read_word(5'd0, 7'd1);
        set_colour(8'hFF);
        put_word(8'h5A);
        put_word(CH_BS);
        read_word(5'd1, 7'd0);
        read_word(5'd1, 7'd1);

        colours[0] = 8'h00;
        colours[1] = 8'hFF;
        colours[2] = 8'($urandom);
        colours[3] = 8'h1E;
        colours[4] = 8'($urandom);
        colours[5] = RESET_COLOR;
        first_words = words_sent;
        for (int p = 0; p < 6; p++) begin
            set_colour(colours[p]);
            random_phase(first_words + (p + 1) * PHASE_WORDS);
            // sender pause until the block has answered everything
            wait_all_results();
        end

        wait_all_results();
        repeat (16) @(posedge aclk);
        $display("Covered %0d words: %0d puts and %0d cell reads under %0d attribute settings,",
                 words_sent, puts_sent, reads_sent, colours_set);
        $display("with scrolls, last-column writes, a long output hold-off and drain pauses.");
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
